// ----- rtl/core/gdcg_pkg.sv -----
package gdcg_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned UPC_W     = 5;
    localparam int unsigned STROKE_W  = 6;
    localparam int unsigned COUNT_W   = 3;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_LINE_OPCODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_OPCODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_OPCODE = 2'd2;

    localparam logic [7:0] LINE_OPCODE_RST  = 8'd33;
    localparam logic [7:0] RECT_OPCODE_RST  = 8'd34;
    localparam logic [7:0] CLEAR_OPCODE_RST = 8'd37;

    localparam logic [7:0] ROW_FLIP     = 8'd63;
    localparam logic [7:0] TRACE_OFFSET = 8'd13;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_TRACE = 2'd1,
        CMD_DIGIT = 2'd2,
        CMD_CHAR  = 2'd3
    } cmd_t;

    // byte source selected by a microcode word
    typedef enum logic [3:0] {
        SRC_CLEAR_OP,
        SRC_LINE_OP,
        SRC_STROKE_OP,
        SRC_X0,
        SRC_Y0,
        SRC_X1,
        SRC_Y1,
        SRC_TRACE_R0,
        SRC_TRACE_R1,
        SRC_COL0,
        SRC_ROW0,
        SRC_COL1,
        SRC_ROW1,
        SRC_ONES,
        SRC_ZERO,
        SRC_FILL
    } src_t;

    // sequencing after the current step
    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_END,
        SEQ_RECT_BR,
        SEQ_LOOP
    } seq_t;

    typedef struct packed {
        src_t src;
        seq_t seq;
    } uword_t;

    localparam logic [UPC_W-1:0] UC_CLEAR  = 5'd0;
    localparam logic [UPC_W-1:0] UC_TRACE  = 5'd5;
    localparam logic [UPC_W-1:0] UC_STROKE = 5'd13;
    localparam logic [UPC_W-1:0] UC_LAST   = 5'd23;

    typedef struct packed {
        logic       rect;
        logic [2:0] c0;
        logic [3:0] r0;
        logic [2:0] c1;
        logic [3:0] r1;
        logic       fill;
    } stroke_t;

    typedef struct packed {
        logic                ok;
        logic [STROKE_W-1:0] first;
        logic [COUNT_W-1:0]  count;
    } range_t;

    function automatic uword_t uw(input src_t src, input seq_t seq);
        uword_t w;
        w.src = src;
        w.seq = seq;
        return w;
    endfunction

    function automatic uword_t ucode(input logic [UPC_W-1:0] upc);
        uword_t w;
        unique case (upc)
            5'd0:    w = uw(SRC_CLEAR_OP, SEQ_NEXT);
            5'd1:    w = uw(SRC_X0, SEQ_NEXT);
            5'd2:    w = uw(SRC_Y0, SEQ_NEXT);
            5'd3:    w = uw(SRC_X1, SEQ_NEXT);
            5'd4:    w = uw(SRC_Y1, SEQ_END);
            5'd5:    w = uw(SRC_LINE_OP, SEQ_NEXT);
            5'd6:    w = uw(SRC_X0, SEQ_NEXT);
            5'd7:    w = uw(SRC_TRACE_R0, SEQ_NEXT);
            5'd8:    w = uw(SRC_X0, SEQ_NEXT);
            5'd9:    w = uw(SRC_TRACE_R1, SEQ_NEXT);
            5'd10:   w = uw(SRC_ONES, SEQ_NEXT);
            5'd11:   w = uw(SRC_ZERO, SEQ_NEXT);
            5'd12:   w = uw(SRC_ZERO, SEQ_END);
            5'd13:   w = uw(SRC_STROKE_OP, SEQ_NEXT);
            5'd14:   w = uw(SRC_COL0, SEQ_NEXT);
            5'd15:   w = uw(SRC_ROW0, SEQ_NEXT);
            5'd16:   w = uw(SRC_COL1, SEQ_NEXT);
            5'd17:   w = uw(SRC_ROW1, SEQ_NEXT);
            5'd18:   w = uw(SRC_ONES, SEQ_NEXT);
            5'd19:   w = uw(SRC_ONES, SEQ_NEXT);
            5'd20:   w = uw(SRC_ONES, SEQ_RECT_BR);
            5'd21:   w = uw(SRC_FILL, SEQ_NEXT);
            5'd22:   w = uw(SRC_FILL, SEQ_NEXT);
            5'd23:   w = uw(SRC_FILL, SEQ_LOOP);
            default: w = uw(SRC_ZERO, SEQ_END);
        endcase
        return w;
    endfunction

    function automatic stroke_t mk(input int rect, input int c0, input int r0,
                                   input int c1, input int r1, input int fill);
        stroke_t s;
        s.rect = rect[0];
        s.c0   = 3'(c0);
        s.r0   = 4'(r0);
        s.c1   = 3'(c1);
        s.r1   = 4'(r1);
        s.fill = fill[0];
        return s;
    endfunction

    function automatic stroke_t stroke_rom(input logic [STROKE_W-1:0] idx);
        stroke_t s;
        case (idx)
            6'd0:    s = mk(1, 0, 0, 4, 8, 0);   // digit 0
            6'd1:    s = mk(0, 2, 0, 2, 8, 0);   // digit 1
            6'd2:    s = mk(0, 0, 0, 4, 0, 0);   // digit 2
            6'd3:    s = mk(0, 0, 4, 4, 4, 0);
            6'd4:    s = mk(0, 0, 8, 4, 8, 0);
            6'd5:    s = mk(0, 4, 0, 4, 4, 0);
            6'd6:    s = mk(0, 0, 4, 0, 8, 0);
            6'd7:    s = mk(0, 0, 0, 4, 0, 0);   // digit 3
            6'd8:    s = mk(0, 0, 4, 4, 4, 0);
            6'd9:    s = mk(0, 0, 8, 4, 8, 0);
            6'd10:   s = mk(0, 4, 0, 4, 8, 0);
            6'd11:   s = mk(0, 0, 0, 0, 4, 0);   // digit 4
            6'd12:   s = mk(0, 0, 4, 4, 4, 0);
            6'd13:   s = mk(0, 4, 0, 4, 8, 0);
            6'd14:   s = mk(0, 0, 0, 4, 0, 0);   // digit 5
            6'd15:   s = mk(0, 0, 4, 4, 4, 0);
            6'd16:   s = mk(0, 0, 8, 4, 8, 0);
            6'd17:   s = mk(0, 0, 0, 0, 4, 0);
            6'd18:   s = mk(0, 4, 4, 4, 8, 0);
            6'd19:   s = mk(0, 0, 0, 4, 0, 0);   // digit 6
            6'd20:   s = mk(0, 0, 4, 4, 4, 0);
            6'd21:   s = mk(0, 0, 8, 4, 8, 0);
            6'd22:   s = mk(0, 0, 0, 0, 8, 0);
            6'd23:   s = mk(0, 4, 4, 4, 8, 0);
            6'd24:   s = mk(0, 0, 0, 4, 0, 0);   // digit 7
            6'd25:   s = mk(0, 4, 0, 0, 8, 0);
            6'd26:   s = mk(1, 0, 0, 4, 8, 0);   // digit 8
            6'd27:   s = mk(0, 0, 4, 4, 4, 0);
            6'd28:   s = mk(1, 0, 0, 4, 4, 0);   // digit 9
            6'd29:   s = mk(0, 4, 4, 4, 8, 0);
            6'd30:   s = mk(1, 0, 0, 3, 3, 0);   // o
            6'd31:   s = mk(0, 0, 0, 4, 0, 0);   // C
            6'd32:   s = mk(0, 0, 8, 4, 8, 0);
            6'd33:   s = mk(0, 0, 0, 0, 8, 0);
            6'd34:   s = mk(1, 0, 4, 4, 8, 0);   // b
            6'd35:   s = mk(0, 0, 0, 0, 8, 0);
            6'd36:   s = mk(1, 0, 4, 4, 8, 0);   // p
            6'd37:   s = mk(0, 0, 8, 0, 11, 0);
            6'd38:   s = mk(0, 0, 4, 0, 8, 0);   // m
            6'd39:   s = mk(0, 4, 4, 4, 8, 0);
            6'd40:   s = mk(0, 2, 6, 2, 8, 0);
            6'd41:   s = mk(0, 0, 4, 2, 6, 0);
            6'd42:   s = mk(0, 2, 6, 4, 4, 0);
            6'd43:   s = mk(1, 1, 7, 2, 8, 1);   // full stop, white fill
            6'd44:   s = mk(0, 0, 4, 4, 4, 0);   // minus
            default: s = mk(0, 0, 0, 0, 0, 0);
        endcase
        return s;
    endfunction

    function automatic range_t rng(input int first, input int count);
        range_t r;
        r.ok    = (count != 0);
        r.first = 6'(first);
        r.count = 3'(count);
        return r;
    endfunction

    function automatic range_t glyph_range(input logic is_char, input logic [7:0] g);
        range_t r;
        if (!is_char) begin
            case (g)
                8'd0:    r = rng(0, 1);
                8'd1:    r = rng(1, 1);
                8'd2:    r = rng(2, 5);
                8'd3:    r = rng(7, 4);
                8'd4:    r = rng(11, 3);
                8'd5:    r = rng(14, 5);
                8'd6:    r = rng(19, 5);
                8'd7:    r = rng(24, 2);
                8'd8:    r = rng(26, 2);
                8'd9:    r = rng(28, 2);
                default: r = rng(0, 0);
            endcase
        end else begin
            case (g)
                8'h6F:   r = rng(30, 1);
                8'h43:   r = rng(31, 3);
                8'h62:   r = rng(34, 2);
                8'h70:   r = rng(36, 2);
                8'h6D:   r = rng(38, 5);
                8'h2E:   r = rng(43, 1);
                8'h2D:   r = rng(44, 1);
                default: r = rng(0, 0);
            endcase
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/gdcg_ifs.sv -----
interface gdcg_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] x0;
    logic [7:0] y0;
    logic [7:0] x1;
    logic [7:0] y1;
    logic [7:0] glyph;

    modport source (output valid, cmd, x0, y0, x1, y1, glyph, input ready);
    modport sink   (input valid, cmd, x0, y0, x1, y1, glyph, output ready);
endinterface

interface gdcg_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] cmd_byte;
    logic       last;

    modport source (output valid, cmd_byte, last, input ready);
    modport sink   (input valid, cmd_byte, last, output ready);
endinterface

interface gdcg_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/glyph_draw_command_generator_unit.sv -----
// Channel  Dir  Payload                        Transfer
// req      in   cmd, x0, y0, x1, y1, glyph     valid & ready
// bytes    out  cmd_byte, last                 valid & ready
// cfg      in   index, data                    valid & ready (always ready)
//
// One command byte per cycle from the microcode sequencer while bytes is not
// stalled, once the request is taken: 5 bytes for a clear, 8 for a trace
// segment, and for a glyph 8 per line stroke or 11 per rectangle stroke.
// A new request is taken the cycle after the last byte enters the output
// register; a glyph with no strokes is taken and produces nothing.
// Reset restores the three opcodes and empties the sequencer and output.
// A stall on bytes holds the sequencer on its current step.
module glyph_draw_command_generator_unit (
    input  logic       clk,
    input  logic       rst_n,
    gdcg_req_if.sink   req,
    gdcg_byte_if.source bytes,
    gdcg_cfg_if.sink   cfg
);
    import gdcg_pkg::*;

    logic [7:0]          line_op_reg, rect_op_reg, clear_op_reg;
    logic [7:0]          x0_reg, y0_reg, x1_reg, y1_reg;
    logic                busy_reg, busy_next;
    logic [UPC_W-1:0]    upc_reg, upc_next;
    logic [STROKE_W-1:0] idx_reg, idx_next;
    logic [COUNT_W-1:0]  left_reg, left_next;
    logic                out_valid_reg;
    logic [7:0]          out_byte_reg;
    logic                out_last_reg;

    logic       req_xfer;
    logic       advance;
    logic       loop_pt;
    logic       fin;
    uword_t     w;
    stroke_t    s;
    range_t     gr;
    logic [7:0] row;
    logic [7:0] byte_sel;

    assign cfg.ready = 1'b1;
    assign req.ready = !busy_reg;
    assign req_xfer  = req.valid && !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_op_reg  <= LINE_OPCODE_RST;
            rect_op_reg  <= RECT_OPCODE_RST;
            clear_op_reg <= CLEAR_OPCODE_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_LINE_OPCODE:  line_op_reg  <= cfg.data;
                REG_RECT_OPCODE:  rect_op_reg  <= cfg.data;
                REG_CLEAR_OPCODE: clear_op_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            x0_reg <= req.x0;
            y0_reg <= req.y0;
            x1_reg <= req.x1;
            y1_reg <= req.y1;
        end
    end

    assign w       = ucode(upc_reg);
    assign s       = stroke_rom(idx_reg);
    assign gr      = glyph_range(req.cmd[0], req.glyph);
    assign row     = ROW_FLIP - y0_reg;
    assign advance = busy_reg && (!out_valid_reg || bytes.ready);
    assign loop_pt = (w.seq == SEQ_LOOP) || ((w.seq == SEQ_RECT_BR) && !s.rect);
    assign fin     = (w.seq == SEQ_END) || (loop_pt && (left_reg == COUNT_W'(1)));

    always_comb
    begin
        unique case (w.src)
            SRC_CLEAR_OP:  byte_sel = clear_op_reg;
            SRC_LINE_OP:   byte_sel = line_op_reg;
            SRC_STROKE_OP: byte_sel = s.rect ? rect_op_reg : line_op_reg;
            SRC_X0:        byte_sel = x0_reg;
            SRC_Y0:        byte_sel = y0_reg;
            SRC_X1:        byte_sel = x1_reg;
            SRC_Y1:        byte_sel = y1_reg;
            SRC_TRACE_R0:  byte_sel = y0_reg + TRACE_OFFSET;
            SRC_TRACE_R1:  byte_sel = y1_reg + TRACE_OFFSET;
            SRC_COL0:      byte_sel = x0_reg + {5'd0, s.c0};
            SRC_ROW0:      byte_sel = row + {4'd0, s.r0};
            SRC_COL1:      byte_sel = x0_reg + {5'd0, s.c1};
            SRC_ROW1:      byte_sel = row + {4'd0, s.r1};
            SRC_ONES:      byte_sel = 8'hFF;
            SRC_ZERO:      byte_sel = 8'h00;
            SRC_FILL:      byte_sel = s.fill ? 8'hFF : 8'h00;
            default:       byte_sel = 8'h00;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        upc_next  = upc_reg;
        idx_next  = idx_reg;
        left_next = left_reg;
        if (req_xfer)
        begin
            unique case (cmd_t'(req.cmd))
                CMD_CLEAR:
                begin
                    busy_next = 1'b1;
                    upc_next  = UC_CLEAR;
                end
                CMD_TRACE:
                begin
                    busy_next = 1'b1;
                    upc_next  = UC_TRACE;
                end
                default:
                begin
                    // unknown glyph: taken, nothing emitted
                    busy_next = gr.ok;
                    upc_next  = UC_STROKE;
                    idx_next  = gr.first;
                    left_next = gr.count;
                end
            endcase
        end
        else if (advance)
        begin
            if (fin)
            begin
                busy_next = 1'b0;
            end
            else if (loop_pt)
            begin
                upc_next  = UC_STROKE;
                idx_next  = idx_reg + STROKE_W'(1);
                left_next = left_reg - COUNT_W'(1);
            end
            else
            begin
                upc_next = upc_reg + UPC_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            upc_reg   <= UC_CLEAR;
            idx_reg   <= '0;
            left_reg  <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            upc_reg   <= upc_next;
            idx_reg   <= idx_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (bytes.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= byte_sel;
            out_last_reg <= fin;
        end
    end

    assign bytes.valid    = out_valid_reg;
    assign bytes.cmd_byte = out_byte_reg;
    assign bytes.last     = out_last_reg;

    a_upc_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> upc_reg <= UC_LAST)
        else $error("microcode step out of range");

    a_stroke_left: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && upc_reg >= UC_STROKE) |-> left_reg != '0)
        else $error("glyph step with no stroke left");

    a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && fin) |=> (out_valid_reg && out_last_reg && !busy_reg))
        else $error("final byte not flagged or sequencer still running");

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !fin) |=> busy_reg)
        else $error("sequencer stopped before final byte");

endmodule
